// File: hdl/pkbd_pkg.sv
`timescale 1ns / 1ps
// shared constants and types for the per-key burst detector
package pkbd_pkg;

	localparam int TABLE_ENTRIES_DEF = 128;
	localparam int RING_LEN_DEF      = 8;

	localparam int ID_W    = 22;
	localparam int CODE_W  = 32;
	localparam int TIME_W  = 64;
	localparam int WIN_W   = 40;
	localparam int CNT_W   = 16;
	localparam int HEAD_W  = 6;
	localparam int DROP_W  = 32;
	localparam int MS_W    = 32;
	localparam int CFG_A_W = 2;
	localparam int CFG_D_W = 40;

	// one million is 2^6 times 15625; the odd part goes by reciprocal
	localparam int DIV_SH    = 6;
	localparam int DIV_Y_W   = WIN_W - DIV_SH;
	localparam int DIV_H_W   = DIV_Y_W / 2;
	localparam int DIV_Q_W   = 21;
	localparam int DIV_ACC_W = DIV_Y_W + DIV_Q_W;
	localparam int DIV_K     = DIV_Y_W;
	localparam logic [DIV_Q_W-1:0] DIV_RECIP = 21'd1099511;
	localparam logic [DIV_Q_W-1:0] DIV_ODD   = 21'd15625;

	localparam logic [CFG_A_W-1:0] REG_SERVER_ID = 2'd0;
	localparam logic [CFG_A_W-1:0] REG_WINDOW_NS = 2'd1;
	localparam logic [CFG_A_W-1:0] REG_THRESHOLD = 2'd2;

	localparam logic [WIN_W-1:0] WINDOW_RST    = 40'd5000000000;
	localparam logic [CNT_W-1:0] THRESHOLD_RST = 16'd32;

	typedef struct packed {
		logic [TIME_W-1:0] start;
		logic [CNT_W-1:0]  count;
		logic [HEAD_W-1:0] head;
	} entry_t;

endpackage

// File: hdl/pkbd_div.sv
`timescale 1ns / 1ps
// window time divided by one million, reciprocal on a shared multiplier over four steps
module pkbd_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [pkbd_pkg::WIN_W-1:0]      dividend,
	output logic                            done,
	output logic [pkbd_pkg::DIV_Q_W-1:0]    quotient
);

	localparam logic [pkbd_pkg::DIV_Y_W:0] ODD_R = (pkbd_pkg::DIV_Y_W+1)'(pkbd_pkg::DIV_ODD);

	typedef enum logic [4:0] {
		D_IDLE = 5'b00001,
		D_LO   = 5'b00010,
		D_HI   = 5'b00100,
		D_EST  = 5'b01000,
		D_FIX  = 5'b10000
	} dstate_t;

	dstate_t                           dstate_q;
	logic                              done_q;
	logic [pkbd_pkg::DIV_Y_W-1:0]      y_q;
	logic [pkbd_pkg::DIV_ACC_W-1:0]    acc_q;
	logic [pkbd_pkg::DIV_Q_W-1:0]      q_q;
	logic [pkbd_pkg::DIV_Y_W:0]        rem_q;
	logic [pkbd_pkg::DIV_Q_W-1:0]      mul_a;
	logic [pkbd_pkg::DIV_Q_W-1:0]      mul_b;
	logic [2*pkbd_pkg::DIV_Q_W-1:0]    mul_p;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (dstate_q)
			D_LO: begin
				mul_a = pkbd_pkg::DIV_Q_W'(y_q[pkbd_pkg::DIV_H_W-1:0]);
				mul_b = pkbd_pkg::DIV_RECIP;
			end
			D_HI: begin
				mul_a = pkbd_pkg::DIV_Q_W'(y_q[pkbd_pkg::DIV_Y_W-1:pkbd_pkg::DIV_H_W]);
				mul_b = pkbd_pkg::DIV_RECIP;
			end
			D_EST: begin
				mul_a = acc_q[pkbd_pkg::DIV_ACC_W-1:pkbd_pkg::DIV_K];
				mul_b = pkbd_pkg::DIV_ODD;
			end
			default: ;
		endcase
	end

	assign mul_p = {{pkbd_pkg::DIV_Q_W{1'b0}}, mul_a} * {{pkbd_pkg::DIV_Q_W{1'b0}}, mul_b};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dstate_q <= D_IDLE;
			done_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (dstate_q)
				D_IDLE: if (start) dstate_q <= D_LO;
				D_LO:   dstate_q <= D_HI;
				D_HI:   dstate_q <= D_EST;
				D_EST:  dstate_q <= D_FIX;
				D_FIX: begin
					done_q   <= 1'b1;
					dstate_q <= D_IDLE;
				end
				default: dstate_q <= D_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (dstate_q)
			D_IDLE: if (start) y_q <= dividend[pkbd_pkg::WIN_W-1:pkbd_pkg::DIV_SH];
			D_LO:   acc_q <= pkbd_pkg::DIV_ACC_W'(mul_p);
			D_HI:   acc_q <= acc_q + {mul_p[pkbd_pkg::DIV_ACC_W-pkbd_pkg::DIV_H_W-1:0],
				{pkbd_pkg::DIV_H_W{1'b0}}};
			D_EST: begin
				q_q   <= acc_q[pkbd_pkg::DIV_ACC_W-1:pkbd_pkg::DIV_K];
				rem_q <= {1'b0, y_q} - mul_p[pkbd_pkg::DIV_Y_W:0];
			end
			D_FIX: if (rem_q >= ODD_R) q_q <= q_q + 1'b1;
			default: ;
		endcase
	end

	assign done     = done_q;
	assign quotient = q_q;

endmodule

// File: hdl/per_key_burst_detector.sv
`timescale 1ns / 1ps
// per-caller burst detector: table scan, window update, event emission
// a filtered-out call is taken and dropped in S_IDLE; a counted call scans the
// table entry by entry up to its key, then reads and updates the entry; a new
// entry scans the whole table and clears its sample ring; a trip runs the
// divider and then emits the ring samples, stalled by out_ready. one call at a time
// reset: asynchronous, clears valid bits, drop counter, registers and sequencer
module per_key_burst_detector #(
	parameter int TABLE_ENTRIES = pkbd_pkg::TABLE_ENTRIES_DEF,
	parameter int RING_LEN      = pkbd_pkg::RING_LEN_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [pkbd_pkg::CFG_A_W-1:0]    cfg_addr,
	input  logic [pkbd_pkg::CFG_D_W-1:0]    cfg_wdata,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            passes_filter,
	input  logic                            is_reply,
	input  logic [pkbd_pkg::ID_W-1:0]       target_id,
	input  logic [pkbd_pkg::ID_W-1:0]       caller_id,
	input  logic [pkbd_pkg::ID_W-1:0]       caller_thread,
	input  logic [pkbd_pkg::CODE_W-1:0]     call_code,
	input  logic [pkbd_pkg::TIME_W-1:0]     now_ns,
	input  logic                            sink_full,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [pkbd_pkg::ID_W-1:0]       event_caller,
	output logic [pkbd_pkg::ID_W-1:0]       event_thread,
	output logic [pkbd_pkg::TIME_W-1:0]     event_time_ns,
	output logic [pkbd_pkg::CNT_W-1:0]      call_count,
	output logic [pkbd_pkg::MS_W-1:0]       elapsed_ms,
	output logic [pkbd_pkg::HEAD_W-1:0]     sample_slot,
	output logic [pkbd_pkg::CODE_W-1:0]     sample_code,
	output logic [pkbd_pkg::DROP_W-1:0]     drops_total,
	output logic                            last
);

	localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int SLOT_W = (RING_LEN > 1) ? $clog2(RING_LEN) : 1;
	localparam int RING_D = TABLE_ENTRIES << SLOT_W;
	localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(TABLE_ENTRIES - 1);
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(RING_LEN - 1);
	localparam logic [pkbd_pkg::HEAD_W:0] RING_LEN_H = (pkbd_pkg::HEAD_W+1)'(RING_LEN);

	typedef enum logic [10:0] {
		S_IDLE  = 11'b00000000001,
		S_SRD   = 11'b00000000010,
		S_SCMP  = 11'b00000000100,
		S_NEW   = 11'b00000001000,
		S_CLR   = 11'b00000010000,
		S_RDENT = 11'b00000100000,
		S_UPD1  = 11'b00001000000,
		S_UPD2  = 11'b00010000000,
		S_DIV   = 11'b00100000000,
		S_ERD   = 11'b01000000000,
		S_EOUT  = 11'b10000000000
	} state_t;

	state_t state_q;

	logic [pkbd_pkg::ID_W-1:0]    server_q;
	logic [pkbd_pkg::WIN_W-1:0]   window_q;
	logic [pkbd_pkg::CNT_W-1:0]   thr_q;
	logic [pkbd_pkg::DROP_W-1:0]  drops_q;
	logic [TABLE_ENTRIES-1:0]     valid_q;

	logic [pkbd_pkg::ID_W-1:0]    caller_q;
	logic [pkbd_pkg::ID_W-1:0]    thread_q;
	logic [pkbd_pkg::CODE_W-1:0]  code_q;
	logic [pkbd_pkg::TIME_W-1:0]  now_q;
	logic                         full_q;

	logic [IDX_W-1:0]             idx_q;
	logic [IDX_W-1:0]             ent_q;
	logic                         free_found_q;
	logic [IDX_W-1:0]             free_idx_q;
	logic [SLOT_W-1:0]            slot_q;
	logic [pkbd_pkg::WIN_W-1:0]   elapsed_q;
	logic                         restart_q;
	logic [pkbd_pkg::CNT_W-1:0]   cnt_out_q;
	logic [pkbd_pkg::MS_W-1:0]    wms_q;

	logic [pkbd_pkg::ID_W-1:0]    key_mem [TABLE_ENTRIES];
	pkbd_pkg::entry_t             ent_mem [TABLE_ENTRIES];
	logic [pkbd_pkg::CODE_W-1:0]  ring_mem [RING_D];
	logic [pkbd_pkg::ID_W-1:0]    key_rd_q;
	pkbd_pkg::entry_t             ent_rd_q;
	logic [pkbd_pkg::CODE_W-1:0]  ring_rd_q;

	logic                         key_we;
	logic                         ent_we;
	pkbd_pkg::entry_t             ent_wd;
	logic                         ring_we;
	logic [SLOT_W-1:0]            ring_wslot;
	logic [pkbd_pkg::CODE_W-1:0]  ring_wd;

	logic                         in_acc;
	logic                         match;
	logic [pkbd_pkg::TIME_W-1:0]  el;
	logic [pkbd_pkg::HEAD_W-1:0]  head_eff;
	logic [pkbd_pkg::HEAD_W-1:0]  head_nxt;
	logic [pkbd_pkg::CNT_W-1:0]   cnt_new;
	logic                         trip;
	logic                         div_start;
	logic                         div_done;
	logic [pkbd_pkg::DIV_Q_W-1:0] div_quo;

	assign in_ready = state_q == S_IDLE;
	assign in_acc   = in_valid && in_ready;
	assign match    = passes_filter && !is_reply && (server_q != '0) && (target_id == server_q);

	assign el       = now_q - ent_rd_q.start;
	assign head_eff = (restart_q || {1'b0, ent_rd_q.head} >= RING_LEN_H) ? '0 : ent_rd_q.head;
	assign head_nxt = ({1'b0, head_eff} + 1'b1 >= RING_LEN_H) ? '0 : head_eff + 1'b1;
	assign cnt_new  = (restart_q ? '0 : ent_rd_q.count) + 1'b1;
	assign trip     = cnt_new == thr_q;

	assign key_we     = state_q == S_NEW;
	assign ent_we     = (state_q == S_NEW) || (state_q == S_UPD2);
	assign ring_we    = (state_q == S_CLR) || (state_q == S_UPD2);
	assign ring_wslot = (state_q == S_CLR) ? slot_q : head_eff[SLOT_W-1:0];
	assign ring_wd    = (state_q == S_CLR) ? '0 : code_q;
	assign div_start  = (state_q == S_UPD2) && trip && !full_q;

	always_comb begin
		ent_wd.start = now_q;
		ent_wd.count = '0;
		ent_wd.head  = '0;
		if (state_q == S_UPD2 && !trip) begin
			ent_wd.start = restart_q ? now_q : ent_rd_q.start;
			ent_wd.count = cnt_new;
			ent_wd.head  = head_nxt;
		end
	end

	// table and ring memories
	always_ff @(posedge clk) begin
		if (key_we)
			key_mem[ent_q] <= caller_q;
		key_rd_q <= key_mem[idx_q];
		if (ent_we)
			ent_mem[ent_q] <= ent_wd;
		ent_rd_q <= ent_mem[ent_q];
		if (ring_we)
			ring_mem[{ent_q, ring_wslot}] <= ring_wd;
		ring_rd_q <= ring_mem[{ent_q, slot_q}];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			server_q <= '0;
			window_q <= pkbd_pkg::WINDOW_RST;
			thr_q    <= pkbd_pkg::THRESHOLD_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				pkbd_pkg::REG_SERVER_ID: server_q <= cfg_wdata[pkbd_pkg::ID_W-1:0];
				pkbd_pkg::REG_WINDOW_NS: window_q <= cfg_wdata[pkbd_pkg::WIN_W-1:0];
				pkbd_pkg::REG_THRESHOLD: thr_q    <= cfg_wdata[pkbd_pkg::CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			caller_q <= caller_id;
			thread_q <= caller_thread;
			code_q   <= call_code;
			now_q    <= now_ns;
			full_q   <= sink_full;
		end
		if (state_q == S_UPD1) begin
			restart_q <= el > {{(pkbd_pkg::TIME_W-pkbd_pkg::WIN_W){1'b0}}, window_q};
			elapsed_q <= (el > {{(pkbd_pkg::TIME_W-pkbd_pkg::WIN_W){1'b0}}, window_q})
				? '0 : el[pkbd_pkg::WIN_W-1:0];
		end
		if (state_q == S_UPD2)
			cnt_out_q <= cnt_new;
		if (div_done)
			wms_q <= pkbd_pkg::MS_W'(div_quo);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			valid_q      <= '0;
			drops_q      <= '0;
			idx_q        <= '0;
			ent_q        <= '0;
			free_found_q <= 1'b0;
			free_idx_q   <= '0;
			slot_q       <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_acc && match) begin
						idx_q        <= '0;
						free_found_q <= 1'b0;
						state_q      <= S_SRD;
					end
				end
				S_SRD: state_q <= S_SCMP;
				S_SCMP: begin
					if (valid_q[idx_q] && key_rd_q == caller_q) begin
						ent_q   <= idx_q;
						state_q <= S_RDENT;
					end else begin
						if (!valid_q[idx_q] && !free_found_q) begin
							free_found_q <= 1'b1;
							free_idx_q   <= idx_q;
						end
						if (idx_q == LAST_IDX) begin
							if (free_found_q) begin
								ent_q   <= free_idx_q;
								state_q <= S_NEW;
							end else if (!valid_q[idx_q]) begin
								ent_q   <= idx_q;
								state_q <= S_NEW;
							end else begin
								state_q <= S_IDLE;
							end
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= S_SRD;
						end
					end
				end
				S_NEW: begin
					valid_q[ent_q] <= 1'b1;
					slot_q         <= '0;
					state_q        <= S_CLR;
				end
				S_CLR: begin
					if (slot_q == LAST_SLOT) begin
						slot_q  <= '0;
						state_q <= S_RDENT;
					end else begin
						slot_q <= slot_q + 1'b1;
					end
				end
				S_RDENT: state_q <= S_UPD1;
				S_UPD1:  state_q <= S_UPD2;
				S_UPD2: begin
					if (!trip) begin
						state_q <= S_IDLE;
					end else if (full_q) begin
						drops_q <= drops_q + 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_done) begin
						slot_q  <= '0;
						state_q <= S_ERD;
					end
				end
				S_ERD: state_q <= S_EOUT;
				S_EOUT: begin
					if (out_ready) begin
						if (slot_q == LAST_SLOT) begin
							slot_q  <= '0;
							state_q <= S_IDLE;
						end else begin
							slot_q  <= slot_q + 1'b1;
							state_q <= S_ERD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	pkbd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (elapsed_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign out_valid     = state_q == S_EOUT;
	assign event_caller  = caller_q;
	assign event_thread  = thread_q;
	assign event_time_ns = now_q;
	assign call_count    = cnt_out_q;
	assign elapsed_ms    = wms_q;
	assign sample_slot   = pkbd_pkg::HEAD_W'(slot_q);
	assign sample_code   = ring_rd_q;
	assign drops_total   = drops_q;
	assign last          = slot_q == LAST_SLOT;

	a_busy_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("result while accepting input");
	a_div_only: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_DIV) else $error("divider finished outside trip");
	a_trip_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> call_count == thr_q) else $error("trip count differs from threshold");
	a_ent_valid: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_UPD1 |-> valid_q[ent_q]) else $error("update of an empty entry");

endmodule

// File: tb/per_key_burst_detector_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for the per-key burst detector
module per_key_burst_detector_tb;

	localparam int ID_W    = pkbd_pkg::ID_W;
	localparam int CODE_W  = pkbd_pkg::CODE_W;
	localparam int TIME_W  = pkbd_pkg::TIME_W;
	localparam int WIN_W   = pkbd_pkg::WIN_W;
	localparam int CNT_W   = pkbd_pkg::CNT_W;
	localparam int HEAD_W  = pkbd_pkg::HEAD_W;
	localparam int DROP_W  = pkbd_pkg::DROP_W;
	localparam int MS_W    = pkbd_pkg::MS_W;
	localparam int CFG_A_W = pkbd_pkg::CFG_A_W;
	localparam int CFG_D_W = pkbd_pkg::CFG_D_W;
	localparam logic [CFG_A_W-1:0] REG_SERVER_ID = pkbd_pkg::REG_SERVER_ID;
	localparam logic [CFG_A_W-1:0] REG_WINDOW_NS = pkbd_pkg::REG_WINDOW_NS;
	localparam logic [CFG_A_W-1:0] REG_THRESHOLD = pkbd_pkg::REG_THRESHOLD;
	localparam logic [WIN_W-1:0]   WINDOW_RST    = pkbd_pkg::WINDOW_RST;
	localparam logic [CNT_W-1:0]   THRESHOLD_RST = pkbd_pkg::THRESHOLD_RST;

	localparam int N_ENT  = pkbd_pkg::TABLE_ENTRIES_DEF;
	localparam int N_RING = pkbd_pkg::RING_LEN_DEF;
	localparam int SETTLE = 2 * N_ENT + N_RING + 5 + 2 * N_RING + 200;

	typedef struct packed {
		logic              pass;
		logic              reply;
		logic [ID_W-1:0]   target;
		logic [ID_W-1:0]   caller;
		logic [ID_W-1:0]   thread;
		logic [CODE_W-1:0] code;
		logic [TIME_W-1:0] now;
		logic              full;
	} call_t;

	typedef struct packed {
		logic [ID_W-1:0]   caller;
		logic [ID_W-1:0]   thread;
		logic [TIME_W-1:0] t;
		logic [CNT_W-1:0]  cnt;
		logic [MS_W-1:0]   ms;
		logic [HEAD_W-1:0] slot;
		logic [CODE_W-1:0] code;
		logic [DROP_W-1:0] drops;
		logic              last;
	} burst_ev_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_A_W-1:0] cfg_addr = '0;
	logic [CFG_D_W-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic passes_filter = 1'b0, is_reply = 1'b0, sink_full = 1'b0;
	logic [ID_W-1:0] target_id = '0, caller_id = '0, caller_thread = '0;
	logic [CODE_W-1:0] call_code = '0;
	logic [TIME_W-1:0] now_ns = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [ID_W-1:0] event_caller, event_thread;
	logic [TIME_W-1:0] event_time_ns;
	logic [CNT_W-1:0] call_count;
	logic [MS_W-1:0] elapsed_ms;
	logic [HEAD_W-1:0] sample_slot;
	logic [CODE_W-1:0] sample_code;
	logic [DROP_W-1:0] drops_total;
	logic last;

	per_key_burst_detector dut (.*);

	always #5 clk = ~clk;

	// predictor state
	logic [ID_W-1:0]   srv;
	logic [WIN_W-1:0]  win;
	logic [CNT_W-1:0]  thr;
	logic              tb_valid [N_ENT];
	logic [ID_W-1:0]   tb_key   [N_ENT];
	logic [TIME_W-1:0] tb_start [N_ENT];
	logic [CNT_W-1:0]  tb_cnt   [N_ENT];
	logic [HEAD_W-1:0] tb_head  [N_ENT];
	logic [CODE_W-1:0] tb_ring  [N_ENT][N_RING];
	logic [DROP_W-1:0] tb_drops;

	call_t     call_q[$];
	burst_ev_t expected_ev[$];
	call_t     cur;
	int        errors = 0, n_results = 0, n_trips = 0, n_drops = 0, n_calls = 0;
	bit        quiet = 0;

	function automatic void predict_call(call_t c);
		int e;
		logic [HEAD_W-1:0] hd;
		logic [TIME_W-1:0] ms64;
		burst_ev_t r;
		e = -1;
		if (!c.pass || c.reply || srv == 0 || c.target != srv)
			return;
		for (int i = 0; i < N_ENT; i++)
			if (e < 0 && tb_valid[i] && tb_key[i] == c.caller)
				e = i;
		for (int i = 0; i < N_ENT; i++)
			if (e < 0 && !tb_valid[i]) begin
				e = i;
				tb_valid[i] = 1;
				tb_key[i] = c.caller;
				tb_start[i] = c.now;
				tb_cnt[i] = 0;
				tb_head[i] = 0;
				for (int k = 0; k < N_RING; k++)
					tb_ring[i][k] = '0;
			end
		if (e < 0)
			return;
		if (c.now - tb_start[e] > {24'd0, win}) begin
			tb_start[e] = c.now;
			tb_cnt[e] = 0;
			tb_head[e] = 0;
		end
		hd = (tb_head[e] >= N_RING) ? '0 : tb_head[e];
		tb_ring[e][hd] = c.code;
		tb_head[e] = (hd + 1 >= N_RING) ? '0 : hd + 1'b1;
		tb_cnt[e] = tb_cnt[e] + 1'b1;
		if (tb_cnt[e] != thr)
			return;
		if (c.full) begin
			tb_drops = tb_drops + 1'b1;
			n_drops++;
		end else begin
			n_trips++;
			ms64 = (c.now - tb_start[e]) / 64'd1000000;
			for (int k = 0; k < N_RING; k++) begin
				r.caller = c.caller;
				r.thread = c.thread;
				r.t = c.now;
				r.cnt = tb_cnt[e];
				r.ms = ms64[MS_W-1:0];
				r.slot = HEAD_W'(k);
				r.code = tb_ring[e][k];
				r.drops = tb_drops;
				r.last = (k == N_RING - 1);
				expected_ev.push_back(r);
			end
		end
		tb_start[e] = c.now;
		tb_cnt[e] = 0;
		tb_head[e] = 0;
	endfunction

	// driver
	int in_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		logic nv;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			nv = 1'b0;
			if (in_valid && in_ready) begin
				predict_call(cur);
				n_calls++;
			end
			if (in_valid && !in_ready) begin
				nv = 1'b1;
			end else if (in_gap > 0) begin
				in_gap--;
			end else if (!quiet && $urandom_range(0, 11) == 0) begin
				in_gap = $urandom_range(0, 17);
			end else if (call_q.size() > 0) begin
				cur = call_q.pop_front();
				passes_filter <= cur.pass;
				is_reply <= cur.reply;
				target_id <= cur.target;
				caller_id <= cur.caller;
				caller_thread <= cur.thread;
				call_code <= cur.code;
				now_ns <= cur.now;
				sink_full <= cur.full;
				nv = 1'b1;
			end
			in_valid <= nv;
		end
	end

	// monitor and receiver pacing
	int out_gap = 0, hold_left = 0;
	bit held = 0;
	always @(posedge clk or negedge arst_n) begin
		burst_ev_t x;
		logic nr;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			nr = 1'b1;
			if (out_valid && out_ready) begin
				n_results++;
				if (expected_ev.size() == 0) begin
					$error("result with nothing expected: caller %0h", event_caller);
					errors++;
				end else begin
					x = expected_ev.pop_front();
					if (event_caller !== x.caller) begin
						$error("event_caller exp %0h got %0h", x.caller, event_caller); errors++; end
					if (event_thread !== x.thread) begin
						$error("event_thread exp %0h got %0h", x.thread, event_thread); errors++; end
					if (event_time_ns !== x.t) begin
						$error("event_time_ns exp %0h got %0h", x.t, event_time_ns); errors++; end
					if (call_count !== x.cnt) begin
						$error("call_count exp %0d got %0d", x.cnt, call_count); errors++; end
					if (elapsed_ms !== x.ms) begin
						$error("elapsed_ms exp %0d got %0d", x.ms, elapsed_ms); errors++; end
					if (sample_slot !== x.slot) begin
						$error("sample_slot exp %0d got %0d", x.slot, sample_slot); errors++; end
					if (sample_code !== x.code) begin
						$error("sample_code exp %0h got %0h", x.code, sample_code); errors++; end
					if (drops_total !== x.drops) begin
						$error("drops_total exp %0d got %0d", x.drops, drops_total); errors++; end
					if (last !== x.last) begin
						$error("last exp %0b got %0b", x.last, last); errors++; end
				end
				// one long hold-off so the block backs up into its input
				if (!held && n_results >= 20) begin
					held = 1;
					hold_left = 3000;
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				nr = 1'b0;
			end else if (out_gap > 0) begin
				out_gap--;
				nr = 1'b0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				out_gap = $urandom_range(0, 17);
				nr = 1'b0;
			end
			out_ready <= nr;
		end
	end

	function automatic call_t mk(logic p, logic rp, logic [ID_W-1:0] tg, logic [ID_W-1:0] cl,
			logic [ID_W-1:0] th, logic [CODE_W-1:0] cd, logic [TIME_W-1:0] t, logic f);
		call_t c;
		c.pass = p; c.reply = rp; c.target = tg; c.caller = cl;
		c.thread = th; c.code = cd; c.now = t; c.full = f;
		return c;
	endfunction

	task automatic cfg_write(logic [CFG_A_W-1:0] a, logic [CFG_D_W-1:0] d);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= a;
		cfg_wdata <= d;
		case (a)
			REG_SERVER_ID: srv = d[ID_W-1:0];
			REG_WINDOW_NS: win = d;
			REG_THRESHOLD: thr = d[CNT_W-1:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_idle();
		do @(posedge clk);
		while (call_q.size() != 0 || in_valid || expected_ev.size() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic logic [TIME_W-1:0] r64();
		return {$urandom, $urandom};
	endfunction

	initial begin
		#10_000_000;
		$display("per_key_burst_detector regression: fail");
		$finish;
	end

	initial begin
		logic [ID_W-1:0] s, pool[6], fill0;
		logic [TIME_W-1:0] t;
		call_t c;
		srv = '0; win = WINDOW_RST; thr = THRESHOLD_RST; tb_drops = '0;
		for (int i = 0; i < N_ENT; i++)
			tb_valid[i] = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// matching disabled at reset
		call_q.push_back(mk(1, 0, 0, 5, 1, 32'h1, 64'd10, 0));
		wait_idle();

		s = '1;
		cfg_write(REG_SERVER_ID, s);
		cfg_write(REG_WINDOW_NS, {CFG_D_W{1'b1}});
		cfg_write(REG_THRESHOLD, 2);
		call_q.push_back(mk(1, 1, s, 7, 1, 32'hAAAA0001, 64'd50, 0));
		call_q.push_back(mk(0, 0, s, 7, 1, 32'hAAAA0002, 64'd60, 0));
		call_q.push_back(mk(1, 0, s - 1, 7, 1, 32'hAAAA0003, 64'd70, 0));
		call_q.push_back(mk(1, 0, s, 7, 2, 32'hFFFFFFFF, 64'd100, 0));
		call_q.push_back(mk(1, 0, s, 7, '1, 32'h0, 64'd200, 0));
		call_q.push_back(mk(1, 0, s, 7, 3, 32'h12345678, 64'd300, 1));
		call_q.push_back(mk(1, 0, s, 7, 3, 32'h9ABCDEF0, 64'd400, 1));
		// time going backwards restarts the window
		call_q.push_back(mk(1, 0, s, '1, 0, 32'h55, 64'd1000000000, 0));
		call_q.push_back(mk(1, 0, s, '1, 0, 32'h66, 64'd5, 0));
		call_q.push_back(mk(1, 0, s, '1, 0, 32'h77, 64'd2000000005, 0));
		call_q.push_back(mk(1, 0, s, 0, '1, 32'h1, '1, 0));
		call_q.push_back(mk(1, 0, s, 0, 0, 32'h2, '1, 0));
		for (int k = 0; k < 9; k++)
			call_q.push_back(mk(1, 0, s, 9, k, $urandom, 64'd5000 + k, 0));
		wait_idle();

		// threshold lowered below a running count
		cfg_write(REG_SERVER_ID, 1);
		cfg_write(REG_THRESHOLD, 3);
		call_q.push_back(mk(1, 0, 1, 11, 0, 32'hC1, 64'd10, 0));
		call_q.push_back(mk(1, 0, 1, 11, 0, 32'hC2, 64'd20, 0));
		wait_idle();
		cfg_write(REG_THRESHOLD, 1);
		call_q.push_back(mk(1, 0, 1, 11, 0, 32'hC3, 64'd30, 0));
		call_q.push_back(mk(1, 0, 1, 12, 0, 32'hC4, 64'd40, 0));
		wait_idle();

		// zero-length window
		cfg_write(REG_WINDOW_NS, 0);
		cfg_write(REG_THRESHOLD, 2);
		call_q.push_back(mk(1, 0, 1, 13, 0, 32'hD1, 64'd900, 0));
		call_q.push_back(mk(1, 0, 1, 13, 0, 32'hD2, 64'd900, 0));
		call_q.push_back(mk(1, 0, 1, 13, 0, 32'hD3, 64'd901, 0));
		call_q.push_back(mk(1, 0, 1, 13, 0, 32'hD4, 64'd902, 0));
		wait_idle();

		// random phases, mostly well-formed bursts from a few callers
		for (int ph = 0; ph < 4; ph++) begin
			s = $urandom_range(1, 22'h3FFFFF);
			cfg_write(REG_SERVER_ID, s);
			cfg_write(REG_WINDOW_NS, (ph == 3) ? 40'd1 : $urandom_range(1000, 50000000));
			cfg_write(REG_THRESHOLD, $urandom_range(1, 6));
			for (int k = 0; k < 6; k++)
				pool[k] = $urandom;
			t = r64();
			for (int n = 0; n < 10; n++) begin
				if ($urandom_range(0, 4) == 0) begin
					c = mk($urandom, $urandom, $urandom_range(0, 1) ? s : ID_W'($urandom),
						$urandom, $urandom, $urandom, r64(), $urandom);
				end else begin
					if ($urandom_range(0, 19) == 0)
						t = t - $urandom_range(1, 1000000);
					else
						t = t + $urandom_range(0, win[31:0] / 3);
					c = mk(1, 0, s, pool[$urandom_range(0, 5)], $urandom, $urandom, t,
						$urandom_range(0, 4) == 0);
				end
				call_q.push_back(c);
				if (n == 5) begin
					// sender pause until everything is out
					while (call_q.size() != 0 || in_valid || expected_ev.size() != 0)
						@(posedge clk);
				end
			end
			wait_idle();
		end

		// fill the table with no idling, then check that newcomers are ignored
		quiet = 1;
		s = 22'h2AAAAA;
		cfg_write(REG_SERVER_ID, s);
		cfg_write(REG_WINDOW_NS, {CFG_D_W{1'b1}});
		cfg_write(REG_THRESHOLD, 16'hFFFF);
		fill0 = 22'h300000;
		for (int n = 0; n < N_ENT + 4; n++)
			call_q.push_back(mk(1, 0, s, fill0 + n, n, $urandom, 64'd100 + n, 0));
		wait_idle();
		cfg_write(REG_THRESHOLD, 2);
		call_q.push_back(mk(1, 0, s, 22'h1FFFF, 1, 32'hEE, 64'd1000, 0));
		call_q.push_back(mk(1, 0, s, fill0, 2, 32'hEF, 64'd1001, 0));
		call_q.push_back(mk(1, 0, s, fill0 + N_ENT + 3, 3, 32'hF0, 64'd1002, 0));
		wait_idle();

		$display("%0d calls accepted, %0d bursts reported, %0d dropped on a full sink,",
			n_calls, n_trips, n_drops);
		$display("%0d sample transactions checked over directed, random and table-full cases",
			n_results);
		if (errors == 0)
			$display("per_key_burst_detector regression: pass");
		else
			$display("per_key_burst_detector regression: fail");
		$finish;
	end

endmodule

// File: per_key_burst_detector.f
hdl/pkbd_pkg.sv
hdl/pkbd_div.sv
hdl/per_key_burst_detector.sv
tb/per_key_burst_detector_tb.sv
